// ----- rtl/edf_pkg.sv -----
// Shared types, codes and defaults of the EDF tick scheduler.
`default_nettype none

package edf_pkg;

   // Default sizing of the task table
   localparam int MAX_TASKS_DEF  = 8;
   localparam int TIME_WIDTH_DEF = 16;

   // Fixed widths of the channel fields and the register port
   localparam int FIELD_W      = 16;
   localparam int TASK_COUNT_W = 4;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 16;

   typedef logic [2:0]              task_id_type;
   typedef logic [7:0]              miss_mask_type;
   typedef logic [FIELD_W-1:0]      field_type;
   typedef logic [CSR_IDX_W-1:0]    csr_idx_type;
   typedef logic [TASK_COUNT_W-1:0] task_count_type;

   // Register indexes
   localparam csr_idx_type CSR_TASK_COUNT = 2'd0;
   localparam csr_idx_type CSR_HORIZON    = 2'd1;

   // Request modes
   localparam logic MODE_TICK = 1'b0;
   localparam logic MODE_LOAD = 1'b1;

   // Register reset values
   localparam task_count_type TASK_COUNT_RST = 4'd0;
   localparam field_type      HORIZON_RST    = 16'hFFFF;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEL,
      ST_UPD,
      ST_FIN
   } state_type;

endpackage

`default_nettype wire

// ----- rtl/edf_req_if.sv -----
// Request channel: tick and task-load transactions.
`default_nettype none

interface edf_req_if;
   logic                  valid;
   logic                  ready;
   logic                  mode;
   edf_pkg::task_id_type  task_index;
   edf_pkg::field_type    compute_time;
   edf_pkg::field_type    relative_deadline;
   edf_pkg::field_type    period;

   modport source (
      output valid, mode, task_index, compute_time, relative_deadline, period,
      input  ready
   );

   modport sink (
      input  valid, mode, task_index, compute_time, relative_deadline, period,
      output ready
   );
endinterface

`default_nettype wire

// ----- rtl/edf_rsp_if.sv -----
// Response channel: one scheduling decision per tick.
`default_nettype none

interface edf_rsp_if;
   logic                    valid;
   logic                    ready;
   edf_pkg::task_id_type    running_task;
   logic                    idle;
   edf_pkg::miss_mask_type  missed_mask;

   modport source (
      output valid, running_task, idle, missed_mask,
      input  ready
   );

   modport sink (
      input  valid, running_task, idle, missed_mask,
      output ready
   );
endinterface

`default_nettype wire

// ----- rtl/edf_task_upd.sv -----
// Per-task end-of-tick update: run accounting, period reload, deadline countdown.
`default_nettype none

module edf_task_upd #(
   parameter int TIME_WIDTH = edf_pkg::TIME_WIDTH_DEF
) (
   input  logic [TIME_WIDTH-1:0] deadline_left,
   input  logic [TIME_WIDTH-1:0] work_left,
   input  logic [TIME_WIDTH-1:0] period_phase,
   input  logic [TIME_WIDTH-1:0] task_compute,
   input  logic [TIME_WIDTH-1:0] task_deadline,
   input  logic [TIME_WIDTH-1:0] task_period,
   input  logic                  is_chosen,
   output logic [TIME_WIDTH-1:0] deadline_nxt,
   output logic [TIME_WIDTH-1:0] work_nxt,
   output logic [TIME_WIDTH-1:0] phase_nxt,
   output logic                  missed
);

   logic [TIME_WIDTH-1:0] work_run;
   logic [TIME_WIDTH-1:0] period_last;

   // the chosen task always has work left, so this never wraps
   assign work_run    = is_chosen ? work_left - TIME_WIDTH'(1) : work_left;
   // period 0 wraps to all ones: a full 2^TIME_WIDTH tick period
   assign period_last = task_period - TIME_WIDTH'(1);

   // reload at period end, otherwise count the deadline down, or flag a miss once it is zero with work left
   always_comb begin
      deadline_nxt = deadline_left;
      work_nxt     = work_run;
      phase_nxt    = period_phase + TIME_WIDTH'(1);
      missed       = 1'b0;
      priority if (period_phase == period_last) begin
         deadline_nxt = task_deadline;
         work_nxt     = task_compute;
         phase_nxt    = '0;
      end else if (deadline_left != '0) begin
         deadline_nxt = deadline_left - TIME_WIDTH'(1);
      end else if (work_run != '0) begin
         missed = 1'b1;
      end else begin
         missed = 1'b0;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/edf_tick_scheduler.sv -----
// Top level of the earliest-deadline-first tick scheduler.
// A load transaction writes one task's compute time, relative deadline and period into
// the task table and restarts that task; it gives no response. A tick transaction keeps
// the request side busy until it completes: the task table has a single registered read
// port and is swept twice over the n active tasks (task_count, capped at MAX_TASKS),
// one entry per cycle plus read latency and drain per sweep, first to pick the task with
// work left and the smallest deadline below the horizon register (lowest index on a
// tie), then to write back each task's decremented counters or period reload, and a
// finish step hands the decision to the response register. The request side is ready
// only between transactions; a finished response waits in the output register while new
// transactions are taken, and a tick that completes meanwhile holds in its finish step
// until the register drains. Table entries come out of reset as zero through per-entry
// valid bits, so no clearing pass is needed. The user must write the registers only while
// the block is idle; the block itself does not enforce this.
`default_nettype none

module edf_tick_scheduler #(
   parameter int MAX_TASKS  = edf_pkg::MAX_TASKS_DEF,
   parameter int TIME_WIDTH = edf_pkg::TIME_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   edf_req_if.sink                        req_if,
   edf_rsp_if.source                      rsp_if,
   input  logic                           csr_wr_en,
   input  edf_pkg::csr_idx_type           csr_index,
   input  logic [edf_pkg::CSR_DATA_W-1:0] csr_wr_data
);

   localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CNT_W = $clog2(MAX_TASKS + 1);
   localparam int CMP_W = (TIME_WIDTH > edf_pkg::FIELD_W) ? TIME_WIDTH : edf_pkg::FIELD_W;

   typedef struct packed {
      logic [TIME_WIDTH-1:0] deadline_left;
      logic [TIME_WIDTH-1:0] work_left;
      logic [TIME_WIDTH-1:0] period_phase;
      logic [TIME_WIDTH-1:0] task_compute;
      logic [TIME_WIDTH-1:0] task_deadline;
      logic [TIME_WIDTH-1:0] task_period;
   } task_rec_type;

   // task table
   task_rec_type          task_mem [MAX_TASKS];
   logic [MAX_TASKS-1:0]  vld_ff, vld_in;
   task_rec_type          rd_data_ff;
   logic                  rd_vbit_ff;
   logic [IDX_W-1:0]      rd_addr;
   logic                  mem_we;
   logic [IDX_W-1:0]      mem_waddr;
   task_rec_type          mem_wdata;

   // sequencer and scan state
   edf_pkg::state_type    state_ff, state_in;
   logic [CNT_W-1:0]      rd_cnt_ff, rd_cnt_in;
   logic [CNT_W-1:0]      n_ff, n_in;
   logic [CNT_W-1:0]      n_cap;
   logic                  pipe_vld_ff, pipe_vld_in;
   logic [IDX_W-1:0]      pipe_idx_ff, pipe_idx_in;
   logic [CMP_W-1:0]      best_ff, best_in;
   logic                  found_ff, found_in;
   logic [IDX_W-1:0]      chosen_ff, chosen_in;
   edf_pkg::miss_mask_type missed_ff, missed_in;
   logic                  issue;

   // configuration registers
   edf_pkg::task_count_type task_count_ff;
   edf_pkg::field_type      horizon_ff;

   // response register
   logic                    rsp_valid_ff, rsp_valid_in;
   edf_pkg::task_id_type    rsp_running_ff, rsp_running_in;
   logic                    rsp_idle_ff, rsp_idle_in;
   edf_pkg::miss_mask_type  rsp_missed_ff, rsp_missed_in;

   // datapath
   task_rec_type            rec;
   task_rec_type            load_rec;
   task_rec_type            upd_rec;
   logic [TIME_WIDTH-1:0]   upd_deadline;
   logic [TIME_WIDTH-1:0]   upd_work;
   logic [TIME_WIDTH-1:0]   upd_phase;
   logic                    eligible;
   logic                    upd_missed;
   edf_pkg::miss_mask_type  miss_bit;
   logic                    req_ready;

   // task table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         task_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= task_mem[rd_addr];
      rd_vbit_ff <= vld_ff[rd_addr];
   end

   assign rd_addr = rd_cnt_ff[IDX_W-1:0];
   assign issue   = rd_cnt_ff < n_ff;
   assign rec     = rd_vbit_ff ? rd_data_ff : '0;

   // active task count, capped at the table depth
   assign n_cap = (task_count_ff > MAX_TASKS) ? CNT_W'(MAX_TASKS) : CNT_W'(task_count_ff);

   // new entry from a load transaction
   always_comb begin
      load_rec.task_compute  = TIME_WIDTH'(req_if.compute_time);
      load_rec.task_deadline = TIME_WIDTH'(req_if.relative_deadline);
      load_rec.task_period   = TIME_WIDTH'(req_if.period);
      load_rec.work_left     = TIME_WIDTH'(req_if.compute_time);
      load_rec.deadline_left = TIME_WIDTH'(req_if.relative_deadline);
      load_rec.period_phase  = '0;
   end

   // selection compare
   assign eligible = (rec.work_left != '0) && (CMP_W'(rec.deadline_left) < best_ff);

   // per-task update unit, shared by every entry of the write-back sweep
   edf_task_upd #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_upd (
      .deadline_left (rec.deadline_left),
      .work_left     (rec.work_left),
      .period_phase  (rec.period_phase),
      .task_compute  (rec.task_compute),
      .task_deadline (rec.task_deadline),
      .task_period   (rec.task_period),
      .is_chosen     (found_ff && (chosen_ff == pipe_idx_ff)),
      .deadline_nxt  (upd_deadline),
      .work_nxt      (upd_work),
      .phase_nxt     (upd_phase),
      .missed        (upd_missed)
   );

   always_comb begin
      upd_rec.deadline_left = upd_deadline;
      upd_rec.work_left     = upd_work;
      upd_rec.period_phase  = upd_phase;
      upd_rec.task_compute  = rec.task_compute;
      upd_rec.task_deadline = rec.task_deadline;
      upd_rec.task_period   = rec.task_period;
   end

   // tasks above the mask width never carry work, so their bit drops out
   assign miss_bit = edf_pkg::miss_mask_type'(64'(1) << pipe_idx_ff);

   // sequencer: next state and outputs
   always_comb begin
      state_in       = state_ff;
      rd_cnt_in      = rd_cnt_ff;
      n_in           = n_ff;
      pipe_vld_in    = 1'b0;
      pipe_idx_in    = pipe_idx_ff;
      best_in        = best_ff;
      found_in       = found_ff;
      chosen_in      = chosen_ff;
      missed_in      = missed_ff;
      vld_in         = vld_ff;
      mem_we         = 1'b0;
      mem_waddr      = pipe_idx_ff;
      mem_wdata      = upd_rec;
      req_ready      = 1'b0;
      rsp_valid_in   = rsp_valid_ff && !rsp_if.ready;
      rsp_running_in = rsp_running_ff;
      rsp_idle_in    = rsp_idle_ff;
      rsp_missed_in  = rsp_missed_ff;

      unique case (state_ff)
         edf_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_if.valid) begin
               if (req_if.mode == edf_pkg::MODE_LOAD) begin
                  if (req_if.task_index < MAX_TASKS) begin
                     mem_we                              = 1'b1;
                     mem_waddr                           = IDX_W'(req_if.task_index);
                     mem_wdata                           = load_rec;
                     vld_in[IDX_W'(req_if.task_index)]   = 1'b1;
                  end
               end else begin
                  state_in  = edf_pkg::ST_SEL;
                  rd_cnt_in = '0;
                  n_in      = n_cap;
                  best_in   = CMP_W'(horizon_ff);
                  found_in  = 1'b0;
                  chosen_in = '0;
                  missed_in = '0;
               end
            end
         end

         // sweep one: earliest eligible deadline
         edf_pkg::ST_SEL: begin
            if (issue) begin
               rd_cnt_in   = rd_cnt_ff + CNT_W'(1);
               pipe_vld_in = 1'b1;
               pipe_idx_in = rd_addr;
            end
            if (pipe_vld_ff && eligible) begin
               best_in   = CMP_W'(rec.deadline_left);
               found_in  = 1'b1;
               chosen_in = pipe_idx_ff;
            end
            if (!issue && !pipe_vld_ff) begin
               state_in  = edf_pkg::ST_UPD;
               rd_cnt_in = '0;
            end
         end

         // sweep two: write back each task's counters
         edf_pkg::ST_UPD: begin
            if (issue) begin
               rd_cnt_in   = rd_cnt_ff + CNT_W'(1);
               pipe_vld_in = 1'b1;
               pipe_idx_in = rd_addr;
            end
            if (pipe_vld_ff) begin
               mem_we              = 1'b1;
               mem_waddr           = pipe_idx_ff;
               mem_wdata           = upd_rec;
               vld_in[pipe_idx_ff] = 1'b1;
               if (upd_missed) begin
                  missed_in = missed_ff | miss_bit;
               end
            end
            if (!issue && !pipe_vld_ff) begin
               state_in  = edf_pkg::ST_FIN;
               rd_cnt_in = '0;
            end
         end

         // hand the decision to the response register once it is free
         edf_pkg::ST_FIN: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_running_in = found_ff ? edf_pkg::task_id_type'(chosen_ff) : '0;
               rsp_idle_in    = !found_ff;
               rsp_missed_in  = missed_ff;
               state_in       = edf_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = edf_pkg::ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= edf_pkg::ST_IDLE;
         rd_cnt_ff    <= '0;
         n_ff         <= '0;
         pipe_vld_ff  <= 1'b0;
         found_ff     <= 1'b0;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_cnt_ff    <= rd_cnt_in;
         n_ff         <= n_in;
         pipe_vld_ff  <= pipe_vld_in;
         found_ff     <= found_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // scan and response payload
   always_ff @(posedge clock) begin
      pipe_idx_ff    <= pipe_idx_in;
      best_ff        <= best_in;
      chosen_ff      <= chosen_in;
      missed_ff      <= missed_in;
      rsp_running_ff <= rsp_running_in;
      rsp_idle_ff    <= rsp_idle_in;
      rsp_missed_ff  <= rsp_missed_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         task_count_ff <= edf_pkg::TASK_COUNT_RST;
         horizon_ff    <= edf_pkg::HORIZON_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            edf_pkg::CSR_TASK_COUNT: begin
               task_count_ff <= csr_wr_data[edf_pkg::TASK_COUNT_W-1:0];
            end
            edf_pkg::CSR_HORIZON: begin
               horizon_ff <= csr_wr_data[edf_pkg::FIELD_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // ports
   assign req_if.ready        = req_ready;
   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.running_task = rsp_running_ff;
   assign rsp_if.idle         = rsp_idle_ff;
   assign rsp_if.missed_mask  = rsp_missed_ff;

   // a response only appears out of the finish step
   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == edf_pkg::ST_FIN))
      else $error("response raised outside the finish step");

   // an accepted tick starts the selection sweep
   a_tick_starts_sel: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_ready && req_if.mode == edf_pkg::MODE_TICK)
      |=> (state_ff == edf_pkg::ST_SEL))
      else $error("tick transaction did not start selection");

   // the read counter never runs past the active task count
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      rd_cnt_ff <= n_ff)
      else $error("table sweep ran past the active tasks");

   // a chosen task is always one of the active tasks
   a_chosen_active: assert property (@(posedge clock) disable iff (reset)
      found_ff |-> (CNT_W'(chosen_ff) < n_ff))
      else $error("chosen task outside the active range");

   // an idle decision reports task zero
   a_idle_task_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_idle_ff) |-> (rsp_running_ff == '0))
      else $error("idle response names a task");

endmodule

`default_nettype wire
